// ----- rtl/centroid_polar_angle_sort_macros.svh -----
// Assertion macros for the polar angle sort block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef CENTROID_POLAR_ANGLE_SORT_MACROS_SVH
`define CENTROID_POLAR_ANGLE_SORT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define CPAS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cpas assertion failed");

// Next-cycle implication, checked while out of reset.
`define CPAS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cpas assertion failed");

`endif

// ----- rtl/cpas_pkg.sv -----
// Shared constants, arctangent table and sort key for the polar angle sort.
// No dependencies.
`default_nettype none
package cpas_pkg;

	parameter int DEFAULT_MAX_POINTS = 64;
	parameter int COORD_W = 24;
	parameter int ANG_W = 16;
	parameter int KEY_W = 17;
	parameter int SUM_W = 31;
	parameter int DIVN_W = 32;
	parameter int DIVD_W = 8;
	parameter int CORDIC_W = 46;
	parameter int Z_W = 34;
	parameter int ATAN_W = 30;
	parameter int CORDIC_STEPS = 30;
	parameter int STEP_W = 5;
	parameter int NORM_BIT = 40;

	function automatic logic [ATAN_W-1:0] atan_tab(input logic [STEP_W-1:0] i);
		logic [ATAN_W-1:0] v;
		case (i)
			5'd0: v = 30'h20000000;
			5'd1: v = 30'h12E4051D;
			5'd2: v = 30'h09FB385B;
			5'd3: v = 30'h051111D4;
			5'd4: v = 30'h028B0D43;
			5'd5: v = 30'h0145D7E1;
			5'd6: v = 30'h00A2F61E;
			5'd7: v = 30'h00517C55;
			5'd8: v = 30'h0028BE53;
			5'd9: v = 30'h00145F2E;
			5'd10: v = 30'h000A2F98;
			5'd11: v = 30'h000517CC;
			5'd12: v = 30'h00028BE6;
			5'd13: v = 30'h000145F3;
			5'd14: v = 30'h0000A2F9;
			5'd15: v = 30'h0000517C;
			5'd16: v = 30'h000028BE;
			5'd17: v = 30'h0000145F;
			5'd18: v = 30'h00000A2F;
			5'd19: v = 30'h00000517;
			5'd20: v = 30'h0000028B;
			5'd21: v = 30'h00000145;
			5'd22: v = 30'h000000A2;
			5'd23: v = 30'h00000051;
			5'd24: v = 30'h00000028;
			5'd25: v = 30'h00000014;
			5'd26: v = 30'h0000000A;
			5'd27: v = 30'h00000005;
			5'd28: v = 30'h00000002;
			5'd29: v = 30'h00000001;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Unsigned sort key: the pi code sorts after everything else.
	function automatic logic [KEY_W-1:0] angle_key(input logic [ANG_W-1:0] code);
		logic [KEY_W-1:0] k;
		if (code == 16'h8000) begin
			k = 17'h10000;
		end else begin
			k = {1'b0, code ^ 16'h8000};
		end
		return k;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/cpas_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cpas_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/cpas_div.sv -----
// Restoring divider, one quotient bit per cycle, for the rounded centroid.
// Depends on cpas_pkg.
`default_nettype none
module cpas_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [cpas_pkg::DIVN_W-1:0]  num,
	input  wire logic [cpas_pkg::DIVD_W-1:0]  den,
	output logic                              done,
	output logic      [cpas_pkg::DIVN_W-1:0]  quo
);

	localparam int CW = $clog2(cpas_pkg::DIVN_W);

	logic                          busy_q;
	logic [CW-1:0]                 cnt_q;
	logic [cpas_pkg::DIVN_W-1:0]   nq_q;
	logic [cpas_pkg::DIVD_W-1:0]   rem_q;
	logic [cpas_pkg::DIVD_W-1:0]   den_q;
	logic [cpas_pkg::DIVD_W:0]     trial;
	logic                          ge;

	assign trial = {rem_q, nq_q[cpas_pkg::DIVN_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign quo   = nq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				nq_q   <= num;
				rem_q  <= '0;
				den_q  <= den;
			end else if (busy_q) begin
				rem_q <= ge ? cpas_pkg::DIVD_W'(trial - {1'b0, den_q})
				            : trial[cpas_pkg::DIVD_W-1:0];
				nq_q  <= {nq_q[cpas_pkg::DIVN_W-2:0], ge};
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(cpas_pkg::DIVN_W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/cpas_cordic.sv -----
// Iterative vectoring CORDIC: normalize, quadrant fold, one rotation a cycle.
// Depends on cpas_pkg.
`default_nettype none
module cpas_cordic (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic signed [cpas_pkg::COORD_W:0]  dx,
	input  wire logic signed [cpas_pkg::COORD_W:0]  dy,
	output logic                                    done,
	output logic             [cpas_pkg::ANG_W-1:0]  code
);

	localparam int W = cpas_pkg::CORDIC_W;
	localparam int ZW = cpas_pkg::Z_W;
	localparam logic signed [W-1:0] LIM = W'(1) <<< cpas_pkg::NORM_BIT;
	localparam logic signed [ZW-1:0] QUARTER = ZW'(32'h40000000);
	localparam logic signed [ZW-1:0] HALF = ZW'(32768);

	typedef enum logic [1:0] {C_IDLE, C_NORM, C_ROT, C_FIN} cstate_t;

	cstate_t                          state_q;
	logic signed [W-1:0]              x_q, y_q, ax, ay, xs, ys;
	logic signed [ZW-1:0]             z_q, at, zr, zs;
	logic [cpas_pkg::STEP_W-1:0]      step_q;
	logic                             dyneg_q;
	logic signed [17:0]               r;
	logic signed [17:0]               rc;

	always_comb begin
		ax = x_q[W-1] ? -x_q : x_q;
		ay = y_q[W-1] ? -y_q : y_q;
		xs = x_q >>> step_q;
		ys = y_q >>> step_q;
		at = $signed(ZW'(cpas_pkg::atan_tab(step_q)));
		zr = z_q + HALF;
		zs = zr >>> 16;
		r  = zs[17:0];
		rc = r;
		if (r > 18'sd32767) begin
			rc = -18'sd32768;
		end else if (r < -18'sd32768) begin
			rc = -18'sd32767;
		end
		if (dyneg_q && rc == -18'sd32768) begin
			rc = -18'sd32767;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						dyneg_q <= dy[cpas_pkg::COORD_W];
						x_q     <= W'(dx);
						y_q     <= W'(dy);
						if (dx == '0 && dy == '0) begin
							code <= '0;
							done <= 1'b1;
						end else begin
							state_q <= C_NORM;
						end
					end
				end
				C_NORM: begin
					// shift up until the larger magnitude reaches 2^40, then fold
					if (ax < LIM && ay < LIM) begin
						x_q <= x_q <<< 1;
						y_q <= y_q <<< 1;
					end else begin
						step_q  <= '0;
						state_q <= C_ROT;
						if (x_q[W-1]) begin
							if (!y_q[W-1]) begin
								x_q <= y_q;
								y_q <= -x_q;
								z_q <= QUARTER;
							end else begin
								x_q <= -y_q;
								y_q <= x_q;
								z_q <= -QUARTER;
							end
						end else begin
							z_q <= '0;
						end
					end
				end
				C_ROT: begin
					if (y_q > 0) begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + at;
					end else begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - at;
					end
					step_q <= step_q + 1'b1;
					if (step_q == cpas_pkg::STEP_W'(cpas_pkg::CORDIC_STEPS - 1)) begin
						state_q <= C_FIN;
					end
				end
				C_FIN: begin
					code    <= rc[cpas_pkg::ANG_W-1:0];
					done    <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/centroid_polar_angle_sort.sv -----
// Polar angle sort about the centroid. Points load one request per cycle while
// point_stall is low. After the last point: two divisions for the centroid, then
// per point normalize shifts, fold and 30 rotations (a point on the centroid gets
// code 0 at once), then each of the n results takes a scan of all n angles, plus
// stalls. One set is processed at a time; point_stall stays high from last point
// to last result. Reset (arst_n low) empties the set and drops any run.
`default_nettype none
`include "centroid_polar_angle_sort_macros.svh"
module centroid_polar_angle_sort #(
	parameter int MAX_POINTS = cpas_pkg::DEFAULT_MAX_POINTS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 point_valid,
	output logic                                      point_stall,
	input  wire logic signed [cpas_pkg::COORD_W-1:0]  point_x,
	input  wire logic signed [cpas_pkg::COORD_W-1:0]  point_y,
	input  wire logic                                 last_point,
	output logic                                      result_valid,
	input  wire logic                                 result_stall,
	output logic signed      [cpas_pkg::COORD_W-1:0]  sorted_x,
	output logic signed      [cpas_pkg::COORD_W-1:0]  sorted_y,
	output logic signed      [cpas_pkg::ANG_W-1:0]    angle,
	output logic signed      [cpas_pkg::COORD_W-1:0]  centroid_x,
	output logic signed      [cpas_pkg::COORD_W-1:0]  centroid_y,
	output logic                                      last_result
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int CW = cpas_pkg::COORD_W;
	localparam int SW = cpas_pkg::SUM_W;
	localparam int KW = cpas_pkg::KEY_W + AW;

	typedef enum logic [3:0] {
		S_LOAD, S_DIVX, S_DIVY, S_ARD, S_AWAIT, S_ACORD,
		S_SCAN, S_XRD, S_XWAIT, S_OUT
	} state_t;

	state_t                    state_q;
	logic [CNT_W-1:0]          cnt_q, scan_q;
	logic signed [SW-1:0]      sumx_q, sumy_q;
	logic [AW-1:0]             idx_q, rank_q, sidx_s1, pi_q, bi_q;
	logic                      svld_s1, first_q, bvalid_q;
	logic [cpas_pkg::KEY_W-1:0] pk_q, bk_q;
	logic [cpas_pkg::ANG_W-1:0] bcode_q;
	logic                      div_go_q, cord_go_q;

	// Request acceptance on the point channel.
	logic point_acc;
	assign point_stall = (state_q != S_LOAD);
	assign point_acc   = point_valid && !point_stall;

	// Point stores: x and y written at load, angle written per point.
	logic               ld_we;
	logic [AW-1:0]      xy_raddr, ang_raddr;
	logic [CW-1:0]      rx, ry;
	logic [cpas_pkg::ANG_W-1:0] ra;
	logic               cord_done, div_done;
	logic [cpas_pkg::ANG_W-1:0] cord_code;

	assign ld_we     = point_acc && (cnt_q < CNT_W'(MAX_POINTS));
	assign xy_raddr  = (state_q == S_XRD || state_q == S_XWAIT) ? bi_q : idx_q;
	assign ang_raddr = scan_q[AW-1:0];

	cpas_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_ram_x (
		.clk(clk), .we(ld_we), .waddr(cnt_q[AW-1:0]), .wdata(point_x),
		.raddr(xy_raddr), .rdata(rx)
	);
	cpas_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_ram_y (
		.clk(clk), .we(ld_we), .waddr(cnt_q[AW-1:0]), .wdata(point_y),
		.raddr(xy_raddr), .rdata(ry)
	);
	cpas_ram #(.WIDTH(cpas_pkg::ANG_W), .DEPTH(MAX_POINTS)) u_ram_a (
		.clk(clk), .we(state_q == S_ACORD && cord_done), .waddr(idx_q),
		.wdata(cord_code), .raddr(ang_raddr), .rdata(ra)
	);

	// Centroid: q = (2|sum| + n) / 2n, sign restored afterwards.
	logic signed [SW-1:0]            div_sum;
	logic [SW-1:0]                   div_mag;
	logic [cpas_pkg::DIVN_W-1:0]     div_num, div_quo;
	logic [cpas_pkg::DIVD_W-1:0]     div_den;
	logic [CW-1:0]                   cen_val;

	assign div_sum = (state_q == S_DIVX) ? sumx_q : sumy_q;
	assign div_mag = div_sum[SW-1] ? SW'(-div_sum) : SW'(div_sum);
	assign div_num = {div_mag, 1'b0} + cpas_pkg::DIVN_W'(cnt_q);
	assign div_den = cpas_pkg::DIVD_W'({cnt_q, 1'b0});
	assign cen_val = div_sum[SW-1] ? CW'(-div_quo) : div_quo[CW-1:0];

	cpas_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go_q),
		.num(div_num), .den(div_den), .done(div_done), .quo(div_quo)
	);

	// Offset of the current point from the centroid.
	logic signed [CW:0] dx, dy;
	assign dx = $signed({rx[CW-1], rx}) - $signed({centroid_x[CW-1], centroid_x});
	assign dy = $signed({ry[CW-1], ry}) - $signed({centroid_y[CW-1], centroid_y});

	cpas_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cord_go_q),
		.dx(dx), .dy(dy), .done(cord_done), .code(cord_code)
	);

	// Rank scan: next (key, index) above the previous one, smallest wins.
	logic [KW-1:0] cand;
	logic          gt_prev, lt_best;
	assign cand    = {cpas_pkg::angle_key(ra), sidx_s1};
	assign gt_prev = first_q || (cand > {pk_q, pi_q});
	assign lt_best = !bvalid_q || (cand < {bk_q, bi_q});

	logic last_idx, last_rank;
	assign last_idx  = (CNT_W'(idx_q) == cnt_q - CNT_W'(1));
	assign last_rank = (CNT_W'(rank_q) == cnt_q - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			cnt_q        <= '0;
			sumx_q       <= '0;
			sumy_q       <= '0;
			div_go_q     <= 1'b0;
			cord_go_q    <= 1'b0;
			svld_s1      <= 1'b0;
			bvalid_q     <= 1'b0;
			first_q      <= 1'b1;
			scan_q       <= '0;
			idx_q        <= '0;
			rank_q       <= '0;
			result_valid <= 1'b0;
			last_result  <= 1'b0;
		end else begin
			div_go_q  <= 1'b0;
			cord_go_q <= 1'b0;
			unique case (state_q)
				S_LOAD: begin
					// store while there is room; a dropped last point still starts
					if (ld_we) begin
						cnt_q  <= cnt_q + CNT_W'(1);
						sumx_q <= sumx_q + SW'(point_x);
						sumy_q <= sumy_q + SW'(point_y);
					end
					if (point_acc && last_point) begin
						div_go_q <= 1'b1;
						state_q  <= S_DIVX;
					end
				end
				S_DIVX: begin
					if (div_done) begin
						centroid_x <= cen_val;
						div_go_q   <= 1'b1;
						state_q    <= S_DIVY;
					end
				end
				S_DIVY: begin
					if (div_done) begin
						centroid_y <= cen_val;
						idx_q      <= '0;
						state_q    <= S_ARD;
					end
				end
				S_ARD: state_q <= S_AWAIT;
				S_AWAIT: begin
					cord_go_q <= 1'b1;
					state_q   <= S_ACORD;
				end
				S_ACORD: begin
					if (cord_done) begin
						if (last_idx) begin
							rank_q   <= '0;
							first_q  <= 1'b1;
							scan_q   <= '0;
							svld_s1  <= 1'b0;
							bvalid_q <= 1'b0;
							state_q  <= S_SCAN;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= S_ARD;
						end
					end
				end
				S_SCAN: begin
					// issue reads while entries remain; compare each entry in the cycle after its read
					if (scan_q < cnt_q) begin
						svld_s1 <= 1'b1;
						sidx_s1 <= scan_q[AW-1:0];
						scan_q  <= scan_q + CNT_W'(1);
					end else begin
						svld_s1 <= 1'b0;
						if (!svld_s1) begin
							state_q <= S_XRD;
						end
					end
					if (svld_s1 && gt_prev && lt_best) begin
						bvalid_q <= 1'b1;
						bk_q     <= cpas_pkg::angle_key(ra);
						bi_q     <= sidx_s1;
						bcode_q  <= ra;
					end
				end
				S_XRD: state_q <= S_XWAIT;
				S_XWAIT: begin
					sorted_x     <= rx;
					sorted_y     <= ry;
					angle        <= bcode_q;
					last_result  <= last_rank;
					result_valid <= 1'b1;
					state_q      <= S_OUT;
				end
				S_OUT: begin
					// hold the request until taken, then next rank or back to load
					if (!result_stall) begin
						result_valid <= 1'b0;
						if (last_result) begin
							cnt_q   <= '0;
							sumx_q  <= '0;
							sumy_q  <= '0;
							state_q <= S_LOAD;
						end else begin
							rank_q   <= rank_q + AW'(1);
							pk_q     <= bk_q;
							pi_q     <= bi_q;
							first_q  <= 1'b0;
							scan_q   <= '0;
							svld_s1  <= 1'b0;
							bvalid_q <= 1'b0;
							state_q  <= S_SCAN;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// No point is taken while a result is on offer.
	`CPAS_ASSERT_NOW(a_no_load_during_out, result_valid, point_stall)
	// Delivering the final result reopens the point channel.
	`CPAS_ASSERT_NEXT(a_reopen_after_last,
		result_valid && !result_stall && last_result, !point_stall)
	// The set never grows past its capacity.
	`CPAS_ASSERT_NOW(a_count_bound, 1'b1, cnt_q <= CNT_W'(MAX_POINTS))

endmodule
`default_nettype wire
